@@ src/bsp_pkg.sv @@
// bspline basis evaluation: shared types and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

    localparam int KNOT_BITS  = 24;
    localparam int FRAC_BITS  = 17;
    localparam int VAL_BITS   = FRAC_BITS + 1;
    localparam int MAX_KNOTS  = 64;
    localparam int IDX_BITS   = 6;
    localparam int MAX_DEGREE = 7;
    localparam int DEG_BITS   = 3;
    localparam int CNT_BITS   = 7;
    localparam int DEN_BITS   = KNOT_BITS + 1;
    localparam int NUM_BITS   = KNOT_BITS + VAL_BITS;
    localparam int STEP_BITS  = 5;

    localparam logic [VAL_BITS-1:0] ONE_Q = VAL_BITS'(1) << FRAC_BITS;

    localparam logic [DEG_BITS-1:0] DEGREE_RESET     = 3'd3;
    localparam logic [CNT_BITS-1:0] KNOT_COUNT_RESET = 7'd8;

    // register index, taken from paddr[2]
    localparam logic REG_DEGREE     = 1'b0;
    localparam logic REG_KNOT_COUNT = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_RD_P,
        ST_RD_N,
        ST_BOUND,
        ST_SCAN,
        ST_LD_LEFT,
        ST_LD_RIGHT,
        ST_CAP_RIGHT,
        ST_MUL_R,
        ST_WAIT_R,
        ST_MUL_L,
        ST_WAIT_L,
        ST_EMIT,
        ST_REJECT
    } bsp_state_t;

    typedef struct packed {
        logic start;
    } bsp_div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bsp_div_sts_t;

endpackage

`default_nettype wire

@@ src/bsp_muldiv.sv @@
// shared multiply then restoring divide unit: quo = (a * b) / den, truncated
// uses bsp_pkg; quotient known to fit VAL_BITS since a <= den
`timescale 1ns / 1ps
`default_nettype none

module bsp_muldiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bsp_pkg::bsp_div_cmd_t         cmd,
    input  wire logic [bsp_pkg::KNOT_BITS-1:0] a,
    input  wire logic [bsp_pkg::VAL_BITS-1:0]  b,
    input  wire logic [bsp_pkg::DEN_BITS-1:0]  den,
    output bsp_pkg::bsp_div_sts_t              sts,
    output logic [bsp_pkg::VAL_BITS-1:0]       quo
);
    import bsp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 first_reg, first_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]  num_reg, num_next;
    logic [DEN_BITS-1:0]  den_reg, den_next;
    logic [DEN_BITS-1:0]  rem_reg, rem_next;
    logic [VAL_BITS-1:0]  sh_reg, sh_next;
    logic [VAL_BITS-1:0]  quo_reg, quo_next;
    logic [DEN_BITS:0]    trial;
    logic                 ge;

    assign trial = {rem_reg, sh_reg[VAL_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        first_next = 1'b0;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        quo_next   = quo_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            num_next   = NUM_BITS'(a) * NUM_BITS'(b);
            den_next   = den;
        end
        else if (first_reg)
        begin
            rem_next = DEN_BITS'(num_reg[NUM_BITS-1:VAL_BITS]);
            sh_next  = num_reg[VAL_BITS-1:0];
            cnt_next = STEP_BITS'(VAL_BITS);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_BITS'(trial - {1'b0, den_reg}) : DEN_BITS'(trial);
            sh_next  = {sh_reg[VAL_BITS-2:0], 1'b0};
            quo_next = {quo_reg[VAL_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
    end

    assign sts.busy = busy_reg | first_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

`default_nettype wire

@@ src/bspline_basis_evaluation_core.sv @@
// bspline basis evaluation top level: knot memory, sequencer, output register
// uses bsp_pkg and bsp_muldiv
`timescale 1ns / 1ps
`default_nettype none

// B-spline span search and Cox-de Boor basis evaluator. A load word (kind 0)
// writes one 24-bit knot into a 64-entry table with one write port and one
// registered read port, and leaves the sequencer idle. An evaluate word (kind
// 1) runs under a small sequencer: four table reads check the domain, a
// linear pass over the table finds the span (skipped when the parameter
// equals knot n), then the triangular recurrence runs p(p+1)/2 steps, each of
// two products divided on one shared multiply and restoring-divide unit, and
// each row first reads its left and right knots from the table. The p+1
// results leave one per cycle through an output register while the receiver
// does not stall. in_stall is high from acceptance of an evaluate word until
// its last result is loaded. A zero denominator skips the divider and yields
// zero terms. Knots must be written before they are read; there is no
// clearing pass after reset.

module bspline_basis_evaluation_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb-style configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [bsp_pkg::IDX_BITS-1:0]  knot_index,
    input  wire logic [bsp_pkg::KNOT_BITS-1:0] knot_value,
    input  wire logic [bsp_pkg::KNOT_BITS-1:0] parameter_req,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bsp_pkg::IDX_BITS-1:0]       span,
    output logic [bsp_pkg::DEG_BITS-1:0]       basis_index,
    output logic [bsp_pkg::VAL_BITS-1:0]       basis_value,
    output logic                               last,
    output logic                               domain_error
);
    import bsp_pkg::*;

    bsp_state_t state_reg, state_next;

    // configuration
    logic [DEG_BITS-1:0] degree_reg;
    logic [CNT_BITS-1:0] knot_count_reg;
    logic                cfg_wr;

    // knot memory
    logic [KNOT_BITS-1:0] knot_mem [MAX_KNOTS];
    logic [IDX_BITS-1:0]  rd_addr;
    logic [KNOT_BITS-1:0] rd_data_reg;

    // evaluation context
    logic [KNOT_BITS-1:0] u_reg, u_next;
    logic [DEG_BITS-1:0]  p_reg, p_next;
    logic [CNT_BITS-1:0]  m_reg, m_next;
    logic [IDX_BITS-1:0]  n_reg, n_next;
    logic [IDX_BITS-1:0]  s_reg, s_next;
    logic [IDX_BITS-1:0]  scan_reg, scan_next;
    logic [IDX_BITS-1:0]  pend_idx_reg, pend_idx_next;
    logic                 pend_reg, pend_next;
    logic                 bad_reg, bad_next;
    logic [DEG_BITS-1:0]  j_reg, j_next;
    logic [DEG_BITS-1:0]  r_reg, r_next;
    logic [DEG_BITS-1:0]  k_reg, k_next;
    logic [VAL_BITS-1:0]  saved_reg, saved_next;
    logic [VAL_BITS-1:0]  qr_reg, qr_next;

    // recurrence work registers
    logic [KNOT_BITS-1:0] left_reg  [1:MAX_DEGREE];
    logic [KNOT_BITS-1:0] right_reg [1:MAX_DEGREE];
    logic [VAL_BITS-1:0]  basis_reg [0:MAX_DEGREE];

    logic                 left_we, right_we, basis_r_we, basis_j_we, basis_0_we;
    logic [KNOT_BITS-1:0] diff_val;
    logic [VAL_BITS-1:0]  basis_r_val, basis_j_val;

    // shared divider
    bsp_div_cmd_t         div_cmd;
    bsp_div_sts_t         div_sts;
    logic [KNOT_BITS-1:0] div_a;
    logic [VAL_BITS-1:0]  div_quo;
    logic [KNOT_BITS-1:0] rt, lt;
    logic [DEN_BITS-1:0]  den;

    // step control
    logic                 upd;
    logic [VAL_BITS-1:0]  upd_qr, upd_ql;
    logic                 last_r, last_j;

    // output register
    logic                 out_valid_reg;
    logic                 out_load, out_rej;
    logic [IDX_BITS-1:0]  span_reg;
    logic [DEG_BITS-1:0]  bidx_reg;
    logic [VAL_BITS-1:0]  bval_reg;
    logic                 last_reg, err_reg;

    logic                 in_acc, eval_acc, load_acc, out_acc;
    logic [CNT_BITS-1:0]  m_sat;
    logic [DEG_BITS-1:0]  p_sat;

    // ------------------------------------------------------------------
    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg     <= DEGREE_RESET;
            knot_count_reg <= KNOT_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DEGREE)
                degree_reg <= pwdata[DEG_BITS-1:0];
            else
                knot_count_reg <= pwdata[CNT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_KNOT_COUNT)
            prdata = 32'(knot_count_reg);
        else
            prdata = 32'(degree_reg);
    end

    // ------------------------------------------------------------------
    // handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;
    assign eval_acc = in_acc & (kind == KIND_EVAL);
    assign load_acc = in_acc & (kind == KIND_LOAD);
    assign out_acc  = out_valid_reg & ~out_stall;
    // output register free when empty or being drained this cycle
    assign out_load = ((state_reg == ST_EMIT) | (state_reg == ST_REJECT))
                    & (~out_valid_reg | out_acc);
    assign out_rej  = (state_reg == ST_REJECT);

    assign m_sat = (knot_count_reg > CNT_BITS'(MAX_KNOTS)) ? CNT_BITS'(MAX_KNOTS)
                                                           : knot_count_reg;
    assign p_sat = (degree_reg > DEG_BITS'(MAX_DEGREE)) ? DEG_BITS'(MAX_DEGREE)
                                                        : degree_reg;

    // ------------------------------------------------------------------
    // knot memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (load_acc)
            knot_mem[knot_index] <= knot_value;
        rd_data_reg <= knot_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // recurrence operands
    assign rt     = right_reg[r_reg + 1'b1];
    assign lt     = left_reg[j_reg - r_reg];
    assign den    = DEN_BITS'(rt) + DEN_BITS'(lt);
    assign last_r = (r_reg == j_reg - 1'b1);
    assign last_j = (j_reg == p_reg);

    // step update: den zero skips the divider, else the second quotient lands
    always_comb
    begin
        upd    = 1'b0;
        upd_qr = qr_reg;
        upd_ql = div_quo;
        if (state_reg == ST_MUL_R && den == '0)
        begin
            upd    = 1'b1;
            upd_qr = '0;
            upd_ql = '0;
        end
        else if (state_reg == ST_WAIT_L && div_sts.done)
        begin
            upd = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (eval_acc)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (m_reg < CNT_BITS'(p_reg) + CNT_BITS'(2))
                    state_next = ST_REJECT;
                else
                    state_next = ST_RD_FIRST;
            ST_RD_FIRST:  state_next = ST_RD_LAST;
            ST_RD_LAST:   state_next = ST_RD_P;
            ST_RD_P:      state_next = ST_RD_N;
            ST_RD_N:      state_next = ST_BOUND;
            ST_BOUND:
                if (bad_reg || u_reg > rd_data_reg)
                    state_next = ST_REJECT;
                else if (u_reg == rd_data_reg)
                    state_next = (p_reg == '0) ? ST_EMIT : ST_LD_LEFT;
                else
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_reg >= n_reg && !pend_reg)
                    state_next = (p_reg == '0) ? ST_EMIT : ST_LD_LEFT;
            ST_LD_LEFT:   state_next = ST_LD_RIGHT;
            ST_LD_RIGHT:  state_next = ST_CAP_RIGHT;
            ST_CAP_RIGHT: state_next = ST_MUL_R;
            ST_MUL_R:
                if (den != '0)
                    state_next = ST_WAIT_R;
                else if (!last_r)
                    state_next = ST_MUL_R;
                else if (last_j)
                    state_next = ST_EMIT;
                else
                    state_next = ST_LD_LEFT;
            ST_WAIT_R:
                if (div_sts.done)
                    state_next = ST_MUL_L;
            ST_MUL_L:     state_next = ST_WAIT_L;
            ST_WAIT_L:
                if (div_sts.done)
                begin
                    if (!last_r)
                        state_next = ST_MUL_R;
                    else if (last_j)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_LD_LEFT;
                end
            ST_EMIT:
                if (out_load && k_reg == p_reg)
                    state_next = ST_IDLE;
            ST_REJECT:
                if (out_load)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath control and next values
    always_comb
    begin
        u_next        = u_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        bad_next      = bad_reg;
        j_next        = j_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        saved_next    = saved_reg;
        qr_next       = qr_reg;
        rd_addr       = '0;
        left_we       = 1'b0;
        right_we      = 1'b0;
        diff_val      = '0;
        basis_0_we    = 1'b0;
        basis_r_we    = 1'b0;
        basis_j_we    = 1'b0;
        basis_r_val   = '0;
        basis_j_val   = '0;
        div_cmd.start = 1'b0;
        div_a         = rt;

        case (state_reg)
            ST_IDLE:
                if (eval_acc)
                begin
                    u_next   = parameter_req;
                    p_next   = p_sat;
                    m_next   = m_sat;
                    bad_next = 1'b0;
                end
            ST_CHECK:
                n_next = IDX_BITS'(m_reg - CNT_BITS'(p_reg) - 1'b1);
            ST_RD_FIRST:
                rd_addr = '0;
            // each read lands in the following state: first knot, last knot, knot p
            ST_RD_LAST:
            begin
                rd_addr  = IDX_BITS'(m_reg - 1'b1);
                bad_next = bad_reg | (u_reg < rd_data_reg);
            end
            ST_RD_P:
            begin
                rd_addr  = IDX_BITS'(p_reg);
                bad_next = bad_reg | (u_reg > rd_data_reg);
            end
            ST_RD_N:
            begin
                rd_addr  = n_reg;
                bad_next = bad_reg | (u_reg < rd_data_reg);
            end
            ST_BOUND:
            begin
                basis_0_we = 1'b1;
                j_next     = DEG_BITS'(1);
                if (u_reg == rd_data_reg)
                    s_next = n_reg - 1'b1;
                else
                    s_next = IDX_BITS'(p_reg);
                scan_next = IDX_BITS'(p_reg) + 1'b1;
                k_next    = '0;
            end
            ST_SCAN:
            begin
                // issue one read a cycle, compare the word that came back
                if (scan_reg < n_reg)
                begin
                    rd_addr       = scan_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                if (pend_reg && rd_data_reg <= u_reg)
                    s_next = pend_idx_reg;
            end
            ST_LD_LEFT:
                rd_addr = s_reg + 1'b1 - IDX_BITS'(j_reg);
            ST_LD_RIGHT:
            begin
                rd_addr  = s_reg + IDX_BITS'(j_reg);
                left_we  = 1'b1;
                diff_val = (u_reg > rd_data_reg) ? u_reg - rd_data_reg : '0;
            end
            ST_CAP_RIGHT:
            begin
                right_we   = 1'b1;
                diff_val   = (rd_data_reg > u_reg) ? rd_data_reg - u_reg : '0;
                r_next     = '0;
                saved_next = '0;
            end
            ST_MUL_R:
                if (den != '0)
                begin
                    div_cmd.start = 1'b1;
                    div_a         = rt;
                end
            ST_WAIT_R:
                if (div_sts.done)
                    qr_next = div_quo;
            ST_MUL_L:
            begin
                div_cmd.start = 1'b1;
                div_a         = lt;
            end
            ST_EMIT:
                if (out_load)
                    k_next = k_reg + 1'b1;
            default:
                ;
        endcase

        if (upd)
        begin
            basis_r_we  = 1'b1;
            basis_r_val = saved_reg + upd_qr;
            saved_next  = upd_ql;
            if (last_r)
            begin
                basis_j_we  = 1'b1;
                basis_j_val = upd_ql;
                if (last_j)
                    k_next = '0;
                else
                    j_next = j_reg + 1'b1;
            end
            else
            begin
                r_next = r_reg + 1'b1;
            end
        end
    end

    bsp_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .a     (div_a),
        .b     (basis_reg[r_reg]),
        .den   (den),
        .sts   (div_sts),
        .quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        p_reg        <= p_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        s_reg        <= s_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        bad_reg      <= bad_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        k_reg        <= k_next;
        saved_reg    <= saved_next;
        qr_reg       <= qr_next;
        if (left_we)
            left_reg[j_reg] <= diff_val;
        if (right_we)
            right_reg[j_reg] <= diff_val;
        if (basis_0_we)
            basis_reg[0] <= ONE_Q;
        if (basis_r_we)
            basis_reg[r_reg] <= basis_r_val;
        if (basis_j_we)
            basis_reg[j_reg] <= basis_j_val;
        if (out_load)
        begin
            span_reg <= out_rej ? '0 : s_reg;
            bidx_reg <= out_rej ? '0 : k_reg;
            bval_reg <= out_rej ? '0 : basis_reg[k_reg];
            last_reg <= out_rej | (k_reg == p_reg);
            err_reg  <= out_rej;
        end
    end

    assign out_valid    = out_valid_reg;
    assign span         = span_reg;
    assign basis_index  = bidx_reg;
    assign basis_value  = bval_reg;
    assign last         = last_reg;
    assign domain_error = err_reg;

endmodule

`default_nettype wire

@@ src/bsp_checker.sv @@
// port-level checks for the bspline basis evaluator, bound to the top level
// uses bsp_pkg for the fixed-point one
`timescale 1ns / 1ps
`default_nettype none

module bsp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [bsp_pkg::IDX_BITS-1:0]  span,
    input wire logic [bsp_pkg::DEG_BITS-1:0]  basis_index,
    input wire logic [bsp_pkg::VAL_BITS-1:0]  basis_value,
    input wire logic                          last,
    input wire logic                          domain_error
);
    import bsp_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(basis_value)
            && $stable(basis_index) && $stable(span) && $stable(last))
        else $error("result word changed under stall");

    // a rejection is a single, final, all-zero word
    a_rej_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && domain_error |-> last && span == '0
            && basis_index == '0 && basis_value == '0)
        else $error("malformed rejection word");

    // no basis value exceeds one
    a_partition: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> basis_value <= ONE_Q)
        else $error("basis value above one");

    // within one evaluation the offset climbs by one per word
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |->
            basis_index == $past(basis_index) + 1'b1)
        else $error("basis offset out of sequence");

    // the block does not take input while it still owes results
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall || !in_valid)
        else $error("input taken during evaluation");

endmodule

bind bspline_basis_evaluation_core bsp_checker u_bsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .span         (span),
    .basis_index  (basis_index),
    .basis_value  (basis_value),
    .last         (last),
    .domain_error (domain_error)
);

`default_nettype wire

@@ verif/tb_bspline_basis_evaluation_core.sv @@
// testbench for bspline_basis_evaluation_core: span search and basis checks
// depends on bsp_pkg and the block's rtl; self-checking, no external files
`timescale 1ns / 1ps

module tb_bspline_basis_evaluation_core;
    import bsp_pkg::*;

    localparam logic [2:0] ADDR_DEGREE     = 3'd0;
    localparam logic [2:0] ADDR_KNOT_COUNT = 3'd4;

    // one expected result word
    typedef struct {
        logic [IDX_BITS-1:0] span;
        logic [DEG_BITS-1:0] index;
        logic [VAL_BITS-1:0] value;
        logic                last;
        logic                err;
    } basis_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = KIND_LOAD;
    logic [IDX_BITS-1:0]  knot_index = '0;
    logic [KNOT_BITS-1:0] knot_value = '0;
    logic [KNOT_BITS-1:0] parameter_req = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [IDX_BITS-1:0]  span;
    logic [DEG_BITS-1:0]  basis_index;
    logic [VAL_BITS-1:0]  basis_value;
    logic                 last;
    logic                 domain_error;

    // predictor state: mirror of the knot table and both registers
    logic [KNOT_BITS-1:0] knots [MAX_KNOTS];
    logic [DEG_BITS-1:0]  cur_degree = DEGREE_RESET;
    logic [CNT_BITS-1:0]  cur_count  = KNOT_COUNT_RESET;
    basis_word_t          basis_queue [$];
    int                   fail_count = 0;
    int                   hold_cycles = 0;
    bit                   quiet = 1'b0;

    bspline_basis_evaluation_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #40ms;
        $display("** bspline_basis_evaluation_core: FAILED **");
        $finish;
    end

    // effective degree and knot count after saturation
    function automatic int eff_degree();
        return (cur_degree > MAX_DEGREE) ? MAX_DEGREE : int'(cur_degree);
    endfunction

    function automatic int eff_count();
        return (cur_count > MAX_KNOTS) ? MAX_KNOTS : int'(cur_count);
    endfunction

    function automatic logic [63:0] sub_clamped(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    // span search plus cox-de boor recurrence; queues the expected words
    task automatic predict_basis(logic [KNOT_BITS-1:0] u);
        int p, m, n, s, j, r;
        logic [63:0] lft [MAX_DEGREE+1];
        logic [63:0] rgt [MAX_DEGREE+1];
        logic [63:0] nb  [MAX_DEGREE+1];
        logic [63:0] saved, den, qr, ql;
        basis_word_t w;
        p = eff_degree();
        m = eff_count();
        // rejection: too few knots, or parameter outside the domain
        if (m < p + 2)
        begin
            w = '{0, 0, 0, 1'b1, 1'b1};
            basis_queue.push_back(w);
            return;
        end
        n = m - p - 1;
        if (u < knots[0] || u > knots[m-1] || u < knots[p] || u > knots[n])
        begin
            w = '{0, 0, 0, 1'b1, 1'b1};
            basis_queue.push_back(w);
            return;
        end
        // the end knot maps to the last span
        if (u == knots[n])
            s = n - 1;
        else
        begin
            s = p;
            for (int i = p + 1; i < n; i++)
                if (knots[i] <= u)
                    s = i;
        end
        foreach (lft[i])
        begin
            lft[i] = 0;
            rgt[i] = 0;
            nb[i]  = 0;
        end
        nb[0] = 64'(ONE_Q);
        for (j = 1; j <= p; j++)
        begin
            saved  = 0;
            lft[j] = sub_clamped(u, knots[s+1-j]);
            rgt[j] = sub_clamped(knots[s+j], u);
            for (r = 0; r < j; r++)
            begin
                den = rgt[r+1] + lft[j-r];
                qr  = 0;
                ql  = 0;
                // zero denominator gives zero terms
                if (den != 0)
                begin
                    qr = (rgt[r+1] * nb[r]) / den;
                    ql = (lft[j-r] * nb[r]) / den;
                end
                nb[r] = saved + qr;
                saved = ql;
            end
            nb[j] = saved;
        end
        for (int k = 0; k <= p; k++)
        begin
            w.span  = IDX_BITS'(s);
            w.index = DEG_BITS'(k);
            w.value = VAL_BITS'(nb[k]);
            w.last  = (k == p);
            w.err   = 1'b0;
            basis_queue.push_back(w);
        end
    endtask

    // offer one word, wait for acceptance, then update the prediction
    task automatic send_word(logic k, logic [IDX_BITS-1:0] idx,
                             logic [KNOT_BITS-1:0] kv, logic [KNOT_BITS-1:0] u);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        knot_index    <= idx;
        knot_value    <= kv;
        parameter_req <= u;
        do
            @(posedge clk);
        while (in_stall);
        if (k == KIND_LOAD)
            knots[idx] = kv;
        else
            predict_basis(u);
    endtask

    task automatic load_knot(int idx, logic [KNOT_BITS-1:0] kv);
        send_word(KIND_LOAD, IDX_BITS'(idx), kv, KNOT_BITS'($urandom));
    endtask

    task automatic evaluate(logic [KNOT_BITS-1:0] u);
        send_word(KIND_EVAL, IDX_BITS'($urandom), KNOT_BITS'($urandom), u);
    endtask

    // pick a knot value that keeps the table nondecreasing
    function automatic logic [KNOT_BITS-1:0] fitting_knot(int idx);
        logic [KNOT_BITS-1:0] lo, hi;
        lo = (idx == 0) ? '0 : knots[idx-1];
        hi = (idx == MAX_KNOTS - 1) ? '1 : knots[idx+1];
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return KNOT_BITS'($urandom_range(int'(lo), int'(hi)));
        endcase
    endfunction

    // parameter mostly inside the domain, sometimes on a knot or anywhere
    function automatic logic [KNOT_BITS-1:0] pick_parameter();
        int p, m, n;
        p = eff_degree();
        m = eff_count();
        if (m < p + 2 || $urandom_range(0, 9) == 0)
            return KNOT_BITS'($urandom);
        n = m - p - 1;
        if ($urandom_range(0, 4) == 0)
            return knots[$urandom_range(p, n)];
        return KNOT_BITS'($urandom_range(int'(knots[p]), int'(knots[n])));
    endfunction

    // lower valid and let the block finish, including a trailing knot load
    task automatic drain();
        in_valid <= 1'b0;
        while (basis_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DEGREE)
            cur_degree = data[DEG_BITS-1:0];
        else
            cur_count = data[CNT_BITS-1:0];
    endtask

    task automatic configure(int deg, int cnt);
        drain();
        reg_write(ADDR_DEGREE, 32'(deg));
        reg_write(ADDR_KNOT_COUNT, 32'(cnt));
    endtask

    // fill the whole table first so that no unwritten knot is ever read
    task automatic test_table_fill();
        logic [KNOT_BITS-1:0] acc;
        acc = KNOT_BITS'($urandom_range(1, 5000));
        for (int i = 0; i < MAX_KNOTS; i++)
        begin
            // repeated knots now and then to get zero-width spans
            if ($urandom_range(0, 5) != 0)
                acc = acc + KNOT_BITS'($urandom_range(1, 250000));
            load_knot(i, acc);
        end
    endtask

    // reset settings, extremes of the parameter and of the knots
    task automatic test_directed();
        evaluate(knots[3]);
        evaluate(knots[4]);
        evaluate(knots[0]);
        evaluate('0);
        evaluate('1);
        evaluate(knots[3] + 1);
        evaluate(knots[4] - 1);
        load_knot(MAX_KNOTS - 1, '1);
        configure(1, 2);
        evaluate(knots[0]);
        configure(7, 8);
        evaluate(knots[7]);
        configure(0, 2);
        evaluate(knots[0]);
        evaluate(knots[1]);
        evaluate(knots[0] + 1);
        configure(7, 127);
        evaluate(knots[7]);
        evaluate(knots[56]);
        evaluate(knots[56] + 1);
        evaluate('1);
    endtask

    // random knot rewrites and evaluations under several settings
    task automatic test_random_phases();
        int degs [7] = '{3, 1, 7, 0, 2, 5, 7};
        int cnts [7] = '{8, 2, 64, 9, 30, 20, 16};
        int idx;
        foreach (degs[ph])
        begin
            configure(degs[ph], cnts[ph]);
            repeat (30)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    idx = $urandom_range(0, MAX_KNOTS - 1);
                    load_knot(idx, fitting_knot(idx));
                end
                else
                    evaluate(pick_parameter());
            end
        end
    endtask

    // hold off the receiver while words keep coming
    task automatic test_backpressure();
        configure(4, 40);
        hold_cycles = 3000;
        repeat (12) evaluate(pick_parameter());
    endtask

    // last part of the run without idling on either side
    task automatic test_quiet_tail();
        configure(3, 16);
        quiet = 1'b1;
        repeat (40) evaluate(pick_parameter());
        drain();
    endtask

    // receiver: random stall bursts and the long hold-off
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst = burst - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        basis_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (basis_queue.size() == 0)
            begin
                $error("unexpected result word: span %0d value %0d", span, basis_value);
                fail_count++;
            end
            else
            begin
                w = basis_queue.pop_front();
                if (span !== w.span)
                begin
                    $error("span: expected %0d, got %0d", w.span, span);
                    fail_count++;
                end
                if (basis_index !== w.index)
                begin
                    $error("basis_index: expected %0d, got %0d", w.index, basis_index);
                    fail_count++;
                end
                if (basis_value !== w.value)
                begin
                    $error("basis_value: expected %0d, got %0d", w.value, basis_value);
                    fail_count++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, last);
                    fail_count++;
                end
                if (domain_error !== w.err)
                begin
                    $error("domain_error: expected %0d, got %0d", w.err, domain_error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        foreach (knots[i])
            knots[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_directed();
        test_random_phases();
        test_backpressure();
        test_quiet_tail();
        if (fail_count == 0 && basis_queue.size() == 0)
            $display("** bspline_basis_evaluation_core: PASSED **");
        else
            $display("** bspline_basis_evaluation_core: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/bsp_pkg.sv
src/bsp_muldiv.sv
src/bspline_basis_evaluation_core.sv
src/bsp_checker.sv
verif/tb_bspline_basis_evaluation_core.sv
